### src/lcd_window_fill_sequencer_assert.svh
// ============================================================================
// LCD window fill sequencer assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ============================================================================
`ifndef LCD_WINDOW_FILL_SEQUENCER_ASSERT_SVH
`define LCD_WINDOW_FILL_SEQUENCER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LWFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwfs assertion failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LWFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwfs assertion failed");
`else
`define LWFS_ASSERT_NOW(lbl, ante, cons)
`define LWFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/lwfs_pkg.sv
// ============================================================================
// LCD window fill sequencer package
// Shared constants, register map, configuration struct and sequencer steps.
// ============================================================================
package lwfs_pkg;

    // Field widths that the request and item formats fix.
    localparam int CFG_BITS    = 9;
    localparam int COLOR_BITS  = 16;
    localparam int COUNT_BITS  = 17;
    localparam int RAW_BITS    = 16;

    // Longest pixel run that one item can carry.
    localparam logic [COUNT_BITS-1:0] RUN_MAX = 17'h1FFFF;

    // Panel controller command bytes.
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    // Register map, indexed by word address.
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd0;
    localparam logic [1:0] REG_ROW_OFFSET    = 2'd1;
    localparam logic [1:0] REG_PANEL_WIDTH   = 2'd2;
    localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd3;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] COLUMN_OFFSET_RESET = 9'd18;
    localparam logic [CFG_BITS-1:0] ROW_OFFSET_RESET    = 9'd82;
    localparam logic [CFG_BITS-1:0] PANEL_WIDTH_RESET   = 9'd284;
    localparam logic [CFG_BITS-1:0] PANEL_HEIGHT_RESET  = 9'd76;

    // Depth of the window queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration seen by the front end.
    typedef struct packed {
        logic [CFG_BITS-1:0] column_offset;
        logic [CFG_BITS-1:0] row_offset;
        logic [CFG_BITS-1:0] panel_width;
        logic [CFG_BITS-1:0] panel_height;
    } cfg_t;

    // One step for each item of the command stream.
    typedef enum logic [11:0] {
        STEP_COL_CMD      = 12'b0000_0000_0001,
        STEP_COL_FIRST_HI = 12'b0000_0000_0010,
        STEP_COL_FIRST_LO = 12'b0000_0000_0100,
        STEP_COL_LAST_HI  = 12'b0000_0000_1000,
        STEP_COL_LAST_LO  = 12'b0000_0001_0000,
        STEP_ROW_CMD      = 12'b0000_0010_0000,
        STEP_ROW_FIRST_HI = 12'b0000_0100_0000,
        STEP_ROW_FIRST_LO = 12'b0000_1000_0000,
        STEP_ROW_LAST_HI  = 12'b0001_0000_0000,
        STEP_ROW_LAST_LO  = 12'b0010_0000_0000,
        STEP_WRITE_CMD    = 12'b0100_0000_0000,
        STEP_RUN          = 12'b1000_0000_0000
    } step_t;

endpackage

### src/lcd_window_fill_sequencer.sv
// ============================================================================
// LCD window fill sequencer
// Turns draw requests into the panel controller's window-setup and
// memory-write command stream, ending in one pixel-run item per request.
// ============================================================================
//
//  Channel   Direction  Handshake                  Contents
//  request   in         req_valid / req_stall      action, rectangle, color, raw window
//  item      out        item_valid / item_stall    command or data byte, or pixel run
//  config    in         APB psel/penable/pwrite    offsets and panel size
//
// A filled request produces twelve items, one per cycle unless the item channel stalls;
// the back-end sequencer's single output register starts the next request after the last item.
// A clipped fill that comes out empty produces no items. A request passes through three
// front stages, the queue and the output register before its first item appears.
// The queue holds four windows.
// Reset clears all handshake state; registers return to their documented defaults.
// Either side may stall on its own; a held request or item keeps its contents.
//
`include "lcd_window_fill_sequencer_assert.svh"

module lcd_window_fill_sequencer #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [3:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // Request channel.
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic                                   action,
    input  logic signed [15:0]                     rect_x,
    input  logic signed [15:0]                     rect_y,
    input  logic signed [15:0]                     rect_width,
    input  logic signed [15:0]                     rect_height,
    input  logic [lwfs_pkg::COLOR_BITS-1:0]        fill_color,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_col_start,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_col_end,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_row_start,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_row_end,
    input  logic [lwfs_pkg::COUNT_BITS-1:0]        raw_pixel_count,
    // Item channel.
    output logic                                   item_valid,
    input  logic                                   item_stall,
    output logic                                   is_command,
    output logic                                   is_pixel_run,
    output logic [7:0]                             byte_value,
    output logic [lwfs_pkg::COLOR_BITS-1:0]        run_color,
    output logic [lwfs_pkg::COUNT_BITS-1:0]        run_length,
    output logic                                   select_release,
    output logic                                   last_item
);
    import lwfs_pkg::*;

    localparam int WIN_BITS = 4*COORD_BITS + COLOR_BITS + COUNT_BITS;

    cfg_t                cfg_reg, cfg_next;
    logic                cfg_write;
    logic [CFG_BITS-1:0] read_value;

    logic                win_valid, win_full;
    logic [WIN_BITS-1:0] win_data;
    logic                head_valid, head_pop;
    logic [WIN_BITS-1:0] head_data;

    // Register writes complete in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_COLUMN_OFFSET: cfg_next.column_offset = pwdata[CFG_BITS-1:0];
                REG_ROW_OFFSET:    cfg_next.row_offset    = pwdata[CFG_BITS-1:0];
                REG_PANEL_WIDTH:   cfg_next.panel_width   = pwdata[CFG_BITS-1:0];
                REG_PANEL_HEIGHT:  cfg_next.panel_height  = pwdata[CFG_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_offset <= COLUMN_OFFSET_RESET;
            cfg_reg.row_offset    <= ROW_OFFSET_RESET;
            cfg_reg.panel_width   <= PANEL_WIDTH_RESET;
            cfg_reg.panel_height  <= PANEL_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_COLUMN_OFFSET: read_value = cfg_reg.column_offset;
            REG_ROW_OFFSET:    read_value = cfg_reg.row_offset;
            REG_PANEL_WIDTH:   read_value = cfg_reg.panel_width;
            REG_PANEL_HEIGHT:  read_value = cfg_reg.panel_height;
            default:           read_value = '0;
        endcase
    end

    assign prdata = 32'(read_value);

    // Front end: clipping and window formation.
    lwfs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .action          (action),
        .rect_x          (rect_x),
        .rect_y          (rect_y),
        .rect_width      (rect_width),
        .rect_height     (rect_height),
        .fill_color      (fill_color),
        .raw_col_start   (raw_col_start),
        .raw_col_end     (raw_col_end),
        .raw_row_start   (raw_row_start),
        .raw_row_end     (raw_row_end),
        .raw_pixel_count (raw_pixel_count),
        .cfg             (cfg_reg),
        .win_valid       (win_valid),
        .win_full        (win_full),
        .win_data        (win_data)
    );

    // Window queue between front and back.
    lwfs_queue #(
        .WIDTH (WIN_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (win_valid),
        .full       (win_full),
        .push_data  (win_data),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_data  (head_data)
    );

    // Back end: command stream sequencer.
    lwfs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_data      (head_data),
        .pop            (head_pop),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .is_command     (is_command),
        .is_pixel_run   (is_pixel_run),
        .byte_value     (byte_value),
        .run_color      (run_color),
        .run_length     (run_length),
        .select_release (select_release),
        .last_item      (last_item)
    );

    // The pixel run closes every request and releases chip select.
    `LWFS_ASSERT_NOW(a_run_closes_request, item_valid && is_pixel_run, last_item && select_release)
    // Command items only ever carry one of the three controller commands.
    `LWFS_ASSERT_NOW(a_command_code, item_valid && is_command, byte_value == CMD_COLUMN || byte_value == CMD_ROW || byte_value == CMD_WRITE)
    // After the last item of a request, the next item opens with the column command.
    `LWFS_ASSERT_NEXT(a_request_restart, item_valid && !item_stall && last_item, !item_valid || (is_command && byte_value == CMD_COLUMN))

endmodule

### src/lwfs_front.sv
// ============================================================================
// LCD window fill sequencer front end
// Accepts requests, clips rectangles to the panel, drops empty fills and
// forms the controller window and pixel count in a three-stage pipeline.
// ============================================================================
module lwfs_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic                                   action,
    input  logic signed [15:0]                     rect_x,
    input  logic signed [15:0]                     rect_y,
    input  logic signed [15:0]                     rect_width,
    input  logic signed [15:0]                     rect_height,
    input  logic [lwfs_pkg::COLOR_BITS-1:0]        fill_color,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_col_start,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_col_end,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_row_start,
    input  logic [lwfs_pkg::RAW_BITS-1:0]          raw_row_end,
    input  logic [lwfs_pkg::COUNT_BITS-1:0]        raw_pixel_count,
    input  lwfs_pkg::cfg_t                         cfg,
    output logic                                   win_valid,
    input  logic                                   win_full,
    output logic [4*COORD_BITS+lwfs_pkg::COLOR_BITS+lwfs_pkg::COUNT_BITS-1:0] win_data
);
    import lwfs_pkg::*;

    localparam int WIN_BITS = 4*COORD_BITS + COLOR_BITS + COUNT_BITS;

    // Stage handshake.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_free, s2_free, s3_free;
    logic s1_keep;

    // Stage 1 payload.
    logic                    s1_raw_reg;
    logic                    s1_empty_reg;
    logic [CFG_BITS-1:0]     s1_xl_reg;
    logic [CFG_BITS-1:0]     s1_yl_reg;
    logic signed [17:0]      s1_xr_reg;
    logic signed [17:0]      s1_yr_reg;
    logic [COLOR_BITS-1:0]   s1_color_reg;
    logic [RAW_BITS-1:0]     s1_c0_reg, s1_c1_reg, s1_r0_reg, s1_r1_reg;
    logic [COUNT_BITS-1:0]   s1_count_reg;

    // Stage 2 payload.
    logic                    s2_raw_reg;
    logic [COORD_BITS-1:0]   s2_c0_reg, s2_c1_reg, s2_r0_reg, s2_r1_reg;
    logic [CFG_BITS-1:0]     s2_wc_reg, s2_hc_reg;
    logic [COLOR_BITS-1:0]   s2_color_reg;
    logic [COUNT_BITS-1:0]   s2_count_reg;

    // Stage 3 payload.
    logic [WIN_BITS-1:0]     s3_data_reg;

    // Stage 1 combinational values.
    logic signed [17:0] x_s, y_s, w_s, h_s, pw_s, ph_s;
    logic               early_empty;

    // Stage 2 combinational values.
    logic signed [17:0]    xr_min, yr_min, wc_s, hc_s;
    logic                  late_empty;
    logic [CFG_BITS:0]     c0_sum, c1_sum, r0_sum, r1_sum;
    logic [COORD_BITS-1:0] c0_win, c1_win, r0_win, r1_win;

    // Stage 3 combinational values.
    logic [2*CFG_BITS-1:0]   product;
    logic [COUNT_BITS-1:0]   count_sat;

    // Flow control: a stage moves on when the stage after it is free.
    assign s3_free   = !s3_valid_reg || !win_full;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign req_stall = !s1_free;

    assign s1_valid_next = s1_free ? req_valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? (s1_valid_reg && s1_keep) : s2_valid_reg;
    assign s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage 1: left and top edges, right and bottom sums, early empty test.
    assign x_s  = 18'(rect_x);
    assign y_s  = 18'(rect_y);
    assign w_s  = 18'(rect_width);
    assign h_s  = 18'(rect_height);
    assign pw_s = $signed({9'b0, cfg.panel_width});
    assign ph_s = $signed({9'b0, cfg.panel_height});

    assign early_empty = (x_s >= pw_s) || (y_s >= ph_s) ||
                         (w_s <= 18'sd0) || (h_s <= 18'sd0);

    always_ff @(posedge clk)
    begin
        if (req_valid && s1_free)
        begin
            s1_raw_reg   <= action;
            s1_empty_reg <= early_empty;
            s1_xl_reg    <= x_s[17] ? '0 : x_s[CFG_BITS-1:0];
            s1_yl_reg    <= y_s[17] ? '0 : y_s[CFG_BITS-1:0];
            s1_xr_reg    <= x_s + w_s;
            s1_yr_reg    <= y_s + h_s;
            s1_color_reg <= fill_color;
            s1_c0_reg    <= raw_col_start;
            s1_c1_reg    <= raw_col_end;
            s1_r0_reg    <= raw_row_start;
            s1_r1_reg    <= raw_row_end;
            s1_count_reg <= raw_pixel_count;
        end
    end

    // Stage 2: clip right and bottom edges, size, and offset addresses.
    assign xr_min = (s1_xr_reg > pw_s) ? pw_s : s1_xr_reg;
    assign yr_min = (s1_yr_reg > ph_s) ? ph_s : s1_yr_reg;
    assign wc_s   = xr_min - $signed({9'b0, s1_xl_reg});
    assign hc_s   = yr_min - $signed({9'b0, s1_yl_reg});

    assign late_empty = s1_empty_reg || (wc_s <= 18'sd0) || (hc_s <= 18'sd0);
    assign s1_keep    = s1_raw_reg || !late_empty;

    assign c0_sum = {1'b0, s1_xl_reg} + {1'b0, cfg.column_offset};
    assign c1_sum = {1'b0, xr_min[CFG_BITS-1:0]} + {1'b0, cfg.column_offset} - 10'd1;
    assign r0_sum = {1'b0, s1_yl_reg} + {1'b0, cfg.row_offset};
    assign r1_sum = {1'b0, yr_min[CFG_BITS-1:0]} + {1'b0, cfg.row_offset} - 10'd1;

    // Addresses are cut to the controller's coordinate width.
    assign c0_win = s1_raw_reg ? COORD_BITS'(s1_c0_reg) : COORD_BITS'(16'(c0_sum));
    assign c1_win = s1_raw_reg ? COORD_BITS'(s1_c1_reg) : COORD_BITS'(16'(c1_sum));
    assign r0_win = s1_raw_reg ? COORD_BITS'(s1_r0_reg) : COORD_BITS'(16'(r0_sum));
    assign r1_win = s1_raw_reg ? COORD_BITS'(s1_r1_reg) : COORD_BITS'(16'(r1_sum));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_keep && s2_free)
        begin
            s2_raw_reg   <= s1_raw_reg;
            s2_c0_reg    <= c0_win;
            s2_c1_reg    <= c1_win;
            s2_r0_reg    <= r0_win;
            s2_r1_reg    <= r1_win;
            s2_wc_reg    <= wc_s[CFG_BITS-1:0];
            s2_hc_reg    <= hc_s[CFG_BITS-1:0];
            s2_color_reg <= s1_color_reg;
            s2_count_reg <= s1_count_reg;
        end
    end

    // Stage 3: pixel count with saturation.
    assign product   = {9'b0, s2_wc_reg} * {9'b0, s2_hc_reg};
    assign count_sat = (product > 18'(RUN_MAX)) ? RUN_MAX : product[COUNT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_data_reg <= {s2_c0_reg, s2_c1_reg, s2_r0_reg, s2_r1_reg, s2_color_reg,
                            s2_raw_reg ? s2_count_reg : count_sat};
        end
    end

    assign win_valid = s3_valid_reg;
    assign win_data  = s3_data_reg;

endmodule

### src/lwfs_queue.sv
// ============================================================================
// LCD window fill sequencer window queue
// Small flip-flop FIFO that decouples the front end from the sequencer.
// ============================================================================
module lwfs_queue #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             full,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data
);
    import lwfs_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;
    assign head_data  = store_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/lwfs_back.sv
// ============================================================================
// LCD window fill sequencer back end
// Walks the twelve-item command stream for the window at the queue head and
// presents one item per cycle through an output register while the item channel does not stall.
// ============================================================================
module lwfs_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   head_valid,
    input  logic [4*COORD_BITS+lwfs_pkg::COLOR_BITS+lwfs_pkg::COUNT_BITS-1:0] head_data,
    output logic                                   pop,
    output logic                                   item_valid,
    input  logic                                   item_stall,
    output logic                                   is_command,
    output logic                                   is_pixel_run,
    output logic [7:0]                             byte_value,
    output logic [lwfs_pkg::COLOR_BITS-1:0]        run_color,
    output logic [lwfs_pkg::COUNT_BITS-1:0]        run_length,
    output logic                                   select_release,
    output logic                                   last_item
);
    import lwfs_pkg::*;

    logic [COORD_BITS-1:0] head_c0, head_c1, head_r0, head_r1;
    logic [COLOR_BITS-1:0] head_color;
    logic [COUNT_BITS-1:0] head_count;
    logic [15:0]           c0_ext, c1_ext, r0_ext, r1_ext;

    step_t step_reg, step_next;
    logic  load;

    logic                  item_valid_reg, item_valid_next;
    logic                  is_command_reg, is_command_next;
    logic                  is_pixel_run_reg, is_pixel_run_next;
    logic [7:0]            byte_value_reg, byte_value_next;
    logic [COLOR_BITS-1:0] run_color_reg, run_color_next;
    logic [COUNT_BITS-1:0] run_length_reg, run_length_next;
    logic                  select_release_reg, select_release_next;
    logic                  last_item_reg, last_item_next;

    assign {head_c0, head_c1, head_r0, head_r1, head_color, head_count} = head_data;
    assign c0_ext = 16'(head_c0);
    assign c1_ext = 16'(head_c1);
    assign r0_ext = 16'(head_r0);
    assign r1_ext = 16'(head_r1);

    // A new item enters the output register when a window waits and the register is empty or being taken.
    assign load = head_valid && (!item_valid_reg || !item_stall);
    assign pop  = load && (step_reg == STEP_RUN);
    assign item_valid_next = load || (item_valid_reg && item_stall);

    // Item contents for the current step.
    always_comb
    begin
        is_command_next     = 1'b0;
        is_pixel_run_next   = 1'b0;
        byte_value_next     = '0;
        run_color_next      = '0;
        run_length_next     = '0;
        select_release_next = 1'b0;
        last_item_next      = 1'b0;
        step_next           = step_reg;
        unique case (step_reg)
            STEP_COL_CMD:
            begin
                is_command_next     = 1'b1;
                byte_value_next     = CMD_COLUMN;
                select_release_next = 1'b1;
                step_next           = STEP_COL_FIRST_HI;
            end
            STEP_COL_FIRST_HI:
            begin
                byte_value_next = c0_ext[15:8];
                step_next       = STEP_COL_FIRST_LO;
            end
            STEP_COL_FIRST_LO:
            begin
                byte_value_next = c0_ext[7:0];
                step_next       = STEP_COL_LAST_HI;
            end
            STEP_COL_LAST_HI:
            begin
                byte_value_next = c1_ext[15:8];
                step_next       = STEP_COL_LAST_LO;
            end
            STEP_COL_LAST_LO:
            begin
                byte_value_next     = c1_ext[7:0];
                select_release_next = 1'b1;
                step_next           = STEP_ROW_CMD;
            end
            STEP_ROW_CMD:
            begin
                is_command_next     = 1'b1;
                byte_value_next     = CMD_ROW;
                select_release_next = 1'b1;
                step_next           = STEP_ROW_FIRST_HI;
            end
            STEP_ROW_FIRST_HI:
            begin
                byte_value_next = r0_ext[15:8];
                step_next       = STEP_ROW_FIRST_LO;
            end
            STEP_ROW_FIRST_LO:
            begin
                byte_value_next = r0_ext[7:0];
                step_next       = STEP_ROW_LAST_HI;
            end
            STEP_ROW_LAST_HI:
            begin
                byte_value_next = r1_ext[15:8];
                step_next       = STEP_ROW_LAST_LO;
            end
            STEP_ROW_LAST_LO:
            begin
                byte_value_next     = r1_ext[7:0];
                select_release_next = 1'b1;
                step_next           = STEP_WRITE_CMD;
            end
            STEP_WRITE_CMD:
            begin
                is_command_next     = 1'b1;
                byte_value_next     = CMD_WRITE;
                select_release_next = 1'b1;
                step_next           = STEP_RUN;
            end
            STEP_RUN:
            begin
                is_pixel_run_next   = 1'b1;
                run_color_next      = head_color;
                run_length_next     = head_count;
                select_release_next = 1'b1;
                last_item_next      = 1'b1;
                step_next           = STEP_COL_CMD;
            end
            default:
            begin
                step_next = STEP_COL_CMD;
            end
        endcase
    end

    // Step and output-valid control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_COL_CMD;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= step_next;
            end
            item_valid_reg <= item_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_command_reg     <= is_command_next;
            is_pixel_run_reg   <= is_pixel_run_next;
            byte_value_reg     <= byte_value_next;
            run_color_reg      <= run_color_next;
            run_length_reg     <= run_length_next;
            select_release_reg <= select_release_next;
            last_item_reg      <= last_item_next;
        end
    end

    assign item_valid     = item_valid_reg;
    assign is_command     = is_command_reg;
    assign is_pixel_run   = is_pixel_run_reg;
    assign byte_value     = byte_value_reg;
    assign run_color      = run_color_reg;
    assign run_length     = run_length_reg;
    assign select_release = select_release_reg;
    assign last_item      = last_item_reg;

endmodule
